// ----- design/csje_pkg.sv -----
// ----------------------------------------------------------------------------
// csje_pkg: shared definitions for the CIGAR splice junction extractor
// Field widths, operation codes, register reset value and the item types
// that travel on the input and result channels.
// ----------------------------------------------------------------------------
package csje_pkg;

	localparam int POS_W   = 31;
	localparam int LEN_W   = 28;
	localparam int CODE_W  = 4;
	localparam int FLANK_W = 16;

	localparam logic [FLANK_W-1:0] MIN_FLANK_RESET = 16'd3;

	// Over-long test: skip > LONG_BASE * 4^m, only meaningful below FLANK_LIMIT.
	localparam logic [LEN_W-1:0] LONG_BASE   = 28'd10;
	localparam logic [LEN_W-1:0] FLANK_LIMIT = 28'd13;

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// CIGAR operation codes.
	localparam logic [CODE_W-1:0] OP_M  = 4'd0;
	localparam logic [CODE_W-1:0] OP_I  = 4'd1;
	localparam logic [CODE_W-1:0] OP_D  = 4'd2;
	localparam logic [CODE_W-1:0] OP_N  = 4'd3;
	localparam logic [CODE_W-1:0] OP_S  = 4'd4;
	localparam logic [CODE_W-1:0] OP_H  = 4'd5;
	localparam logic [CODE_W-1:0] OP_P  = 4'd6;
	localparam logic [CODE_W-1:0] OP_EQ = 4'd7;
	localparam logic [CODE_W-1:0] OP_X  = 4'd8;

	typedef struct packed {
		logic              read_start;
		logic [POS_W-1:0]  start_position;
		logic [CODE_W-1:0] op_code;
		logic [LEN_W-1:0]  op_length;
		logic              last_op;
	} in_item_t;

	typedef struct packed {
		logic             junction_valid;
		logic [POS_W-1:0] junction_start;
		logic [POS_W-1:0] junction_end;
		logic             junction_too_long;
		logic             read_done;
		logic             read_ok;
	} out_item_t;

endpackage

// ----- design/cigar_splice_junction_extractor_top.sv -----
// ----------------------------------------------------------------------------
// cigar_splice_junction_extractor_top: splice junctions from CIGAR streams
// Tracks the reference position of a read, watches for M-N-M patterns and
// reports each junction with its flank test, over-long flag and a per-read
// verdict on the last operation.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                            | Carries
//  --------+------------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_item        | one CIGAR operation per item
//  result  | out_valid, out_ready, out_item     | one result item per input item
//  config  | cfg_valid, cfg_ready, cfg_data     | min_flank register write
//
//  An item is held in the input register and then moves to the result
//  register, where its result is offered. One item is taken every cycle
//  while the result side is not stalled; the read-position and window
//  update is a single add, compare and shift. Reset clears the read state
//  and loads min_flank with its default of 3. A stall on the result side
//  holds both registers; the input side keeps accepting until the input
//  register is full as well.
//
module cigar_splice_junction_extractor_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  csje_pkg::in_item_t           in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output csje_pkg::out_item_t          out_item,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [csje_pkg::FLANK_W-1:0] cfg_data
);

	// The register may be written at any time; software is to write it only while idle, which the block does not enforce.
	assign cfg_ready = 1'b1;

	logic [csje_pkg::FLANK_W-1:0] min_flank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_flank_q <= csje_pkg::MIN_FLANK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			min_flank_q <= cfg_data;
		end
	end

	// Input register and handshake. The result register moves whenever it is
	// empty or being taken, and the input register empties into it.
	logic                valid_s1;
	csje_pkg::in_item_t  item_s1;
	logic                out_free;
	logic                s1_adv;

	assign out_free = !out_valid || out_ready;
	assign s1_adv   = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// Read state.
	logic [csje_pkg::POS_W-1:0]  ref_pos_q;
	logic [csje_pkg::CODE_W-1:0] older_code_q;
	logic [csje_pkg::LEN_W-1:0]  older_len_q;
	logic [csje_pkg::CODE_W-1:0] middle_code_q;
	logic [csje_pkg::LEN_W-1:0]  middle_len_q;
	logic [1:0]                  ops_seen_q;
	logic                        read_failed_q;

	// A read start replaces the kept state before the item is looked at.
	logic [csje_pkg::POS_W-1:0]  ref_pos_cur;
	logic [csje_pkg::CODE_W-1:0] older_code_cur;
	logic [csje_pkg::LEN_W-1:0]  older_len_cur;
	logic [csje_pkg::CODE_W-1:0] middle_code_cur;
	logic [csje_pkg::LEN_W-1:0]  middle_len_cur;
	logic [1:0]                  ops_seen_cur;
	logic                        failed_cur;

	always_comb begin
		if (item_s1.read_start) begin
			ref_pos_cur     = item_s1.start_position;
			older_code_cur  = '0;
			older_len_cur   = '0;
			middle_code_cur = '0;
			middle_len_cur  = '0;
			ops_seen_cur    = 2'd0;
			failed_cur      = 1'b0;
		end else begin
			ref_pos_cur     = ref_pos_q;
			older_code_cur  = older_code_q;
			older_len_cur   = older_len_q;
			middle_code_cur = middle_code_q;
			middle_len_cur  = middle_len_q;
			ops_seen_cur    = ops_seen_q;
			failed_cur      = read_failed_q;
		end
	end

	// The junction is recognized when the window holds M then N and this
	// item is M, with at least two earlier operations of the same read behind it.
	logic                       pattern;
	logic [csje_pkg::LEN_W-1:0] shorter;
	logic [csje_pkg::LEN_W-1:0] threshold;
	logic                       flanks_ok;
	logic                       too_long;

	assign pattern = (ops_seen_cur == 2'd2) && (older_code_cur == csje_pkg::OP_M)
		&& (middle_code_cur == csje_pkg::OP_N) && (item_s1.op_code == csje_pkg::OP_M);

	assign shorter = (older_len_cur < item_s1.op_length) ? older_len_cur : item_s1.op_length;

	// 10 * 4^m; with m of 12 or less this still fits the length width.
	assign threshold = csje_pkg::LONG_BASE << {shorter[3:0], 1'b0};

	assign flanks_ok = (older_len_cur >= {12'd0, min_flank_q})
		&& (item_s1.op_length >= {12'd0, min_flank_q});

	assign too_long = pattern && (shorter < csje_pkg::FLANK_LIMIT)
		&& (middle_len_cur > threshold);

	// Reference advance with saturation at the top of the position range.
	logic                       advances;
	logic [csje_pkg::POS_W:0]   pos_sum;
	logic [csje_pkg::POS_W-1:0] ref_pos_next;

	always_comb begin
		case (item_s1.op_code) inside
			csje_pkg::OP_M, csje_pkg::OP_D, csje_pkg::OP_N, csje_pkg::OP_EQ, csje_pkg::OP_X:
				advances = 1'b1;
			default:
				advances = 1'b0;
		endcase
	end

	assign pos_sum = {1'b0, ref_pos_cur} + {4'd0, item_s1.op_length};
	always_comb begin
		if (!advances) begin
			ref_pos_next = ref_pos_cur;
		end else if (pos_sum[csje_pkg::POS_W]) begin
			ref_pos_next = csje_pkg::POS_MAX;
		end else begin
			ref_pos_next = pos_sum[csje_pkg::POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_pos_q     <= '0;
			older_code_q  <= '0;
			older_len_q   <= '0;
			middle_code_q <= '0;
			middle_len_q  <= '0;
			ops_seen_q    <= 2'd0;
			read_failed_q <= 1'b0;
		end else if (s1_adv) begin
			ref_pos_q <= ref_pos_next;
			if (item_s1.last_op) begin
				// The position carries over into a read that has no start mark.
				older_code_q  <= '0;
				older_len_q   <= '0;
				middle_code_q <= '0;
				middle_len_q  <= '0;
				ops_seen_q    <= 2'd0;
				read_failed_q <= 1'b0;
			end else begin
				older_code_q  <= middle_code_cur;
				older_len_q   <= middle_len_cur;
				middle_code_q <= item_s1.op_code;
				middle_len_q  <= item_s1.op_length;
				ops_seen_q    <= (ops_seen_cur == 2'd2) ? 2'd2 : ops_seen_cur + 2'd1;
				read_failed_q <= failed_cur || too_long;
			end
		end
	end

	// Result register.
	csje_pkg::out_item_t res_next;

	always_comb begin
		res_next                   = '0;
		res_next.junction_valid    = pattern && flanks_ok;
		res_next.junction_too_long = too_long;
		res_next.read_done         = item_s1.last_op;
		res_next.read_ok           = item_s1.last_op && !(failed_cur || too_long);
		if (pattern) begin
			res_next.junction_end   = ref_pos_cur;
			res_next.junction_start = ref_pos_cur - {3'd0, middle_len_cur};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_item <= res_next;
		end
	end

	// Checks on the block's own bookkeeping.
	a_ops_seen_range: assert property (@(posedge clk) disable iff (!arst_n)
		ops_seen_q != 2'd3)
		else $error("ops_seen counter left its range");

	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.read_ok |-> out_item.read_done)
		else $error("read verdict given on an item that does not end the read");

	a_junction_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.junction_valid || out_item.junction_too_long)
		|-> out_item.junction_end >= out_item.junction_start)
		else $error("junction ends before it starts");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |-> !in_ready)
		else $error("input taken while both registers are held");

	a_fail_clears_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && item_s1.last_op |=> (read_failed_q == 1'b0) && (ops_seen_q == 2'd0))
		else $error("read state not cleared after the last operation");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CIGAR splice junction extractor
// A queue of CIGAR operations feeds a clocked driver, and a clocked monitor
// checks every result item against a behavioral junction predictor. The run
// goes through several min_flank settings, random idling on both channels
// and one long result-side hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;

	import csje_pkg::*;

	// Codes with no CIGAR meaning; the block must treat them as non-advancing.
	localparam logic [CODE_W-1:0] OP_UNDEF_LO = 4'd9;
	localparam logic [CODE_W-1:0] OP_UNDEF_HI = 4'd15;

	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AT      = 500;
	localparam int CALM_FIRST   = 1200;
	localparam int CALM_LAST    = 1700;
	localparam int MAX_REPORTS  = 10;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	in_item_t           in_item = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_item_t          out_item;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [FLANK_W-1:0] cfg_data = '0;

	cigar_splice_junction_extractor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Operations waiting to be offered, and junction reports still owed by the block.
	in_item_t  pending_ops[$];
	out_item_t expected_junctions[$];

	int error_count = 0;
	int ops_queued = 0;
	int cycle_no = 0;

	// In this window neither side idles, so the block runs at full rate.
	wire calm = (cycle_no >= CALM_FIRST) && (cycle_no < CALM_LAST);

	// ------------------------------------------------------------------
	// Junction predictor: its own copy of the read state and min_flank.
	// ------------------------------------------------------------------
	logic [FLANK_W-1:0] flank_min = MIN_FLANK_RESET;
	logic [POS_W-1:0]   cur_pos = '0;
	logic [CODE_W-1:0]  win_old_code = '0;
	logic [LEN_W-1:0]   win_old_len = '0;
	logic [CODE_W-1:0]  win_mid_code = '0;
	logic [LEN_W-1:0]   win_mid_len = '0;
	logic [1:0]         window_fill = '0;
	logic               read_bad = 1'b0;

	function automatic out_item_t predict_junction(input in_item_t op);
		out_item_t  res;
		logic [LEN_W-1:0] shorter;
		logic [63:0] bound;
		logic [POS_W:0] sum;
		res = '0;
		// A read start reloads the position and forgets everything about the last read.
		if (op.read_start) begin
			cur_pos = op.start_position;
			win_old_code = '0;
			win_old_len = '0;
			win_mid_code = '0;
			win_mid_len = '0;
			window_fill = '0;
			read_bad = 1'b0;
		end
		// M, then N, then this M: the N is a junction.
		if (window_fill == 2'd2 && win_old_code == OP_M && win_mid_code == OP_N &&
				op.op_code == OP_M) begin
			shorter = (win_old_len < op.op_length) ? win_old_len : op.op_length;
			res.junction_end = cur_pos;
			res.junction_start = cur_pos - POS_W'(win_mid_len);
			res.junction_valid = (win_old_len >= LEN_W'(flank_min)) &&
				(op.op_length >= LEN_W'(flank_min));
			// Beyond the flank limit the bound exceeds any length the field can hold.
			if (shorter < FLANK_LIMIT) begin
				bound = 64'(LONG_BASE) << (2 * shorter);
				if (64'(win_mid_len) > bound) begin
					res.junction_too_long = 1'b1;
					read_bad = 1'b1;
				end
			end
		end
		if (op.op_code == OP_M || op.op_code == OP_D || op.op_code == OP_N ||
				op.op_code == OP_EQ || op.op_code == OP_X) begin
			sum = {1'b0, cur_pos} + (POS_W + 1)'(op.op_length);
			cur_pos = (sum > {1'b0, POS_MAX}) ? POS_MAX : sum[POS_W-1:0];
		end
		win_old_code = win_mid_code;
		win_old_len = win_mid_len;
		win_mid_code = op.op_code;
		win_mid_len = op.op_length;
		if (window_fill != 2'd2)
			window_fill = window_fill + 2'd1;
		if (op.last_op) begin
			res.read_done = 1'b1;
			res.read_ok = ~read_bad;
			win_old_code = '0;
			win_old_len = '0;
			win_mid_code = '0;
			win_mid_len = '0;
			window_fill = '0;
			read_bad = 1'b0;
		end
		return res;
	endfunction

	task automatic note_error(input string msg);
		if (error_count < MAX_REPORTS)
			$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			note_error($sformatf("%s expected %h got %h", field, want, got));
	endtask

	// ------------------------------------------------------------------
	// Driver: offers queued operations, idling at random outside the calm
	// window. An accepted item is handed to the predictor at its edge.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_junctions = {expected_junctions, predict_junction(in_item)};
			if (!in_valid || in_ready) begin
				if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
					in_valid <= 1'b1;
					in_item <= pending_ops.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result item against the oldest expectation.
	// Once, after HOLD_AT results, it refuses results for a hold-off counted
	// down from HOLD_CYCLES while the driver keeps offering, so the block
	// fills and must drop in_ready.
	// ------------------------------------------------------------------
	int results_seen = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expected_junctions.size() == 0) begin
					note_error("result item with no expectation waiting");
				end else begin
					want = expected_junctions.pop_front();
					check_field("junction_valid", 32'(want.junction_valid),
						32'(out_item.junction_valid));
					check_field("junction_start", 32'(want.junction_start),
						32'(out_item.junction_start));
					check_field("junction_end", 32'(want.junction_end),
						32'(out_item.junction_end));
					check_field("junction_too_long", 32'(want.junction_too_long),
						32'(out_item.junction_too_long));
					check_field("read_done", 32'(want.read_done), 32'(out_item.read_done));
					check_field("read_ok", 32'(want.read_ok), 32'(out_item.read_ok));
				end
			end
			if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 30);
			end
		end
	end

	// Watchdog: too many cycles in a row with no handshake on any channel.
	int stall_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			cycle_no <= cycle_no + 1;
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic push_op(input logic rs, input logic [POS_W-1:0] spos,
			input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len, input logic last);
		in_item_t op;
		op.read_start = rs;
		op.start_position = spos;
		op.op_code = code;
		op.op_length = len;
		op.last_op = last;
		pending_ops = {pending_ops, op};
		ops_queued++;
	endtask

	function automatic logic [LEN_W-1:0] pick_length();
		case ($urandom_range(9))
			0: return LEN_W'($urandom);
			1: return {LEN_W{1'b1}};
			2: return '0;
			default: return LEN_W'($urandom_range(20));
		endcase
	endfunction

	// Skip lengths cluster around 10 * 4^m, where the over-long test flips.
	function automatic logic [LEN_W-1:0] pick_skip(input int base);
		int roll;
		roll = $urandom_range(99);
		if (roll < 50 && base <= 12)
			return LEN_W'(64'(LONG_BASE) << (2 * base)) + LEN_W'($urandom_range(2)) - 28'd1;
		else if (roll < 75)
			return LEN_W'($urandom_range(400));
		else
			return pick_length();
	endfunction

	// One read: mostly M/N/M patterns with flanks near a common length,
	// mixed with other codes, now and then a lost read start, a missing
	// last operation or a read start in the middle of a read.
	task automatic add_read();
		int n_ops;
		int base;
		int roll;
		logic [CODE_W-1:0] code;
		logic [CODE_W-1:0] prev1;
		logic [CODE_W-1:0] prev2;
		logic [LEN_W-1:0] len;
		logic rs;
		logic last;
		logic [POS_W-1:0] spos;
		n_ops = $urandom_range(1, 8);
		base = $urandom_range(14);
		prev1 = OP_I;
		prev2 = OP_I;
		for (int i = 0; i < n_ops; i++) begin
			roll = $urandom_range(99);
			if (prev2 == OP_M && prev1 == OP_N)
				code = (roll < 70) ? OP_M : CODE_W'($urandom_range(15));
			else if (prev1 == OP_M)
				code = (roll < 45) ? OP_N : (roll < 70) ? OP_M : CODE_W'($urandom_range(15));
			else
				code = (roll < 55) ? OP_M : CODE_W'($urandom_range(15));
			if (code == OP_N)
				len = pick_skip(base);
			else if (code == OP_M && $urandom_range(99) < 70)
				len = LEN_W'(base + $urandom_range(2));
			else
				len = pick_length();
			rs = (i == 0) ? ($urandom_range(99) >= 8) : ($urandom_range(99) < 2);
			spos = ($urandom_range(2) == 0) ? POS_MAX - POS_W'($urandom_range(1000)) :
				POS_W'($urandom);
			last = (i == n_ops - 1) && ($urandom_range(99) >= 8);
			push_op(rs, spos, code, len, last);
			prev2 = prev1;
			prev1 = code;
		end
	endtask

	task automatic run_reads(input int n);
		int target;
		target = ops_queued + n;
		while (ops_queued < target)
			add_read();
	endtask

	// Wait until every queued item is accepted and every result has come back.
	task automatic drain();
		while (pending_ops.size() != 0 || in_valid || expected_junctions.size() != 0)
			@(posedge clk);
	endtask

	// Registers change only while the block is empty.
	task automatic write_min_flank(input logic [FLANK_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		flank_min = value;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, min_flank at its reset value of 3.
		// The very first read has no read start and so begins at position 0.
		push_op(1'b0, '0, OP_M, 28'd5, 1'b0);
		push_op(1'b0, '0, OP_N, 28'd100, 1'b0);
		push_op(1'b0, '0, OP_M, 28'd5, 1'b1);
		// Near the top of the reference: the position saturates, skip is over-long.
		push_op(1'b1, POS_MAX - 31'd40, OP_M, 28'd10, 1'b0);
		push_op(1'b0, '0, OP_N, {LEN_W{1'b1}}, 1'b0);
		push_op(1'b0, POS_MAX, OP_M, {LEN_W{1'b1}}, 1'b1);
		// Short flanks: not reported, but the skip is still over-long.
		push_op(1'b1, 31'd1000, OP_M, 28'd2, 1'b0);
		push_op(1'b0, '0, OP_N, 28'd161, 1'b0);
		push_op(1'b0, '0, OP_M, 28'd2, 1'b1);
		// Flanks of 13 or more can never be over-long, whatever the skip.
		push_op(1'b1, '0, OP_M, 28'd13, 1'b0);
		push_op(1'b0, '0, OP_N, {LEN_W{1'b1}}, 1'b0);
		push_op(1'b0, '0, OP_M, 28'd13, 1'b1);
		// Every other code, advancing or not, including undefined ones.
		push_op(1'b1, 31'h2AAA_AAAA, OP_I, 28'd7, 1'b0);
		push_op(1'b0, '0, OP_D, 28'd11, 1'b0);
		push_op(1'b0, '0, OP_S, 28'd13, 1'b0);
		push_op(1'b0, '0, OP_H, 28'd17, 1'b0);
		push_op(1'b0, '0, OP_P, 28'd19, 1'b0);
		push_op(1'b0, '0, OP_EQ, 28'd23, 1'b0);
		push_op(1'b0, '0, OP_X, 28'd29, 1'b0);
		push_op(1'b0, '0, OP_UNDEF_LO, 28'd31, 1'b0);
		push_op(1'b0, '0, OP_UNDEF_HI, 28'd37, 1'b1);
		// A read with no read start carries on from the previous position.
		push_op(1'b0, '0, OP_M, 28'd0, 1'b0);
		push_op(1'b0, '0, OP_N, 28'd0, 1'b0);
		push_op(1'b0, '0, OP_M, 28'd0, 1'b1);
		drain();

		write_min_flank(16'd0);
		run_reads(300);
		drain();
		write_min_flank(16'hFFFF);
		run_reads(200);
		drain();
		write_min_flank(16'd1);
		run_reads(300);
		drain();
		write_min_flank(FLANK_W'($urandom_range(2, 20)));
		run_reads(400);
		drain();
		write_min_flank(MIN_FLANK_RESET);
		run_reads(425);
		drain();

		// Results pass through the input and result registers after acceptance.
		repeat (8) @(posedge clk);
		if (error_count == 0 && expected_junctions.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
design/csje_pkg.sv
design/cigar_splice_junction_extractor_top.sv
test/tb_top.sv
